### design/egs_pkg.sv
// Package for the exclusive gate switch with blip.
// Holds the item types, state record, command and register codes and helpers.
// No dependencies.
`default_nettype none

package egs_pkg;

  localparam int unsigned DelayWidth = 10;
  localparam int unsigned BlipWidth = 16;
  localparam int unsigned TimeWidth = 32;

  localparam logic [DelayWidth-1:0] SwitchDelayReset = 10'd50;
  localparam logic [BlipWidth-1:0] BlipMaxReset = 16'd10000;

  typedef enum logic [2:0] {
    FN_TICK = 3'd0,
    FN_ENABLE_OUTPUT = 3'd1,
    FN_ENABLE_BUS = 3'd2,
    FN_BUS_DIRECT = 3'd3,
    FN_DISABLE_ALL = 3'd4,
    FN_BLIP = 3'd5,
    FN_CANCEL_BLIP = 3'd6,
    FN_INIT = 3'd7
  } func_t;

  typedef enum logic {
    REG_SWITCH_DELAY = 1'b0,
    REG_BLIP_MAX = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [2:0] func;
    logic [BlipWidth-1:0] blip_ms;
  } in_item_t;

  typedef struct packed {
    logic output_pin;
    logic bus_pin;
    logic output_really_on;
    logic output_requested_settled;
    logic bus_requested_settled;
    logic all_off;
    logic blipping;
  } out_item_t;

  typedef struct packed {
    logic [DelayWidth-1:0] switch_delay_ms;
    logic [BlipWidth-1:0] blip_max_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeWidth-1:0] now_ms;
    logic [TimeWidth-1:0] bus_switch_start;
    logic [TimeWidth-1:0] output_switch_start;
    logic [TimeWidth-1:0] blip_wake_time;
    logic initialized;
    logic bus_requested;
    logic bus_switching;
    logic output_requested;
    logic output_switching;
    logic output_active;
    logic output_pin_level;
    logic bus_pin_level;
  } state_t;

  function automatic logic elapsed(input logic [TimeWidth-1:0] now,
                                   input logic [TimeWidth-1:0] start,
                                   input logic [DelayWidth-1:0] delay);
    logic [TimeWidth-1:0] diff;
    diff = now - start;
    return diff > {{(TimeWidth-DelayWidth){1'b0}}, delay};
  endfunction

endpackage

`default_nettype wire

### design/egs_step.sv
// Next-state and result logic for one item of the gate switch.
// Pure combinational; uses egs_pkg types and helpers.
`default_nettype none

module egs_step (
  input  wire egs_pkg::state_t   st,
  input  wire egs_pkg::cfg_t     cfg,
  input  wire egs_pkg::in_item_t item,
  output egs_pkg::state_t        st_next,
  output egs_pkg::out_item_t     result
);

  egs_pkg::state_t n;
  logic os;
  logic bs;

  always_comb begin
    n = st;
    case (egs_pkg::func_t'(item.func))
      egs_pkg::FN_TICK: begin
        n.now_ms = st.now_ms + {{(egs_pkg::TimeWidth-1){1'b0}}, 1'b1};
        if (st.initialized) begin
          if (n.bus_switching &&
              egs_pkg::elapsed(n.now_ms, n.bus_switch_start, cfg.switch_delay_ms)) begin
            n.output_pin_level = 1'b0;
            n.bus_pin_level = 1'b1;
            n.output_active = 1'b0;
            n.bus_switching = 1'b0;
          end
          if (n.output_switching &&
              egs_pkg::elapsed(n.now_ms, n.output_switch_start, cfg.switch_delay_ms)) begin
            n.output_pin_level = 1'b1;
            n.bus_pin_level = 1'b0;
            n.output_active = 1'b1;
            n.output_switching = 1'b0;
          end
          if (n.output_active) begin
            if ((n.blip_wake_time != '0) && (n.now_ms >= n.blip_wake_time)) begin
              n.output_pin_level = 1'b1;
              n.blip_wake_time = '0;
            end
          end else begin
            n.blip_wake_time = '0;
          end
        end
      end
      egs_pkg::FN_ENABLE_OUTPUT: begin
        if (!(st.output_requested &&
              egs_pkg::elapsed(st.now_ms, st.output_switch_start, cfg.switch_delay_ms))) begin
          n.bus_pin_level = 1'b0;
          n.bus_requested = 1'b0;
          n.bus_switching = 1'b0;
          if (!st.output_requested) begin
            n.output_switch_start = st.now_ms;
            n.output_switching = 1'b1;
            n.output_requested = 1'b1;
          end
        end
      end
      egs_pkg::FN_ENABLE_BUS: begin
        if (!(st.bus_requested &&
              egs_pkg::elapsed(st.now_ms, st.bus_switch_start, cfg.switch_delay_ms))) begin
          n.blip_wake_time = '0;
          n.output_pin_level = 1'b0;
          n.output_requested = 1'b0;
          n.output_switching = 1'b0;
          n.output_active = 1'b0;
          if (!st.bus_requested) begin
            n.bus_switch_start = st.now_ms;
            n.bus_switching = 1'b1;
            n.bus_requested = 1'b1;
          end
        end
      end
      egs_pkg::FN_BUS_DIRECT: begin
        n.blip_wake_time = '0;
        n.output_requested = 1'b0;
        n.output_switching = 1'b0;
        n.output_pin_level = 1'b0;
        n.bus_pin_level = 1'b1;
        n.output_active = 1'b0;
      end
      egs_pkg::FN_BLIP: begin
        if ((item.blip_ms == '0) || (item.blip_ms > cfg.blip_max_ms) || !st.output_active) begin
          n.blip_wake_time = '0;
        end else begin
          n.blip_wake_time = st.now_ms +
                             {{(egs_pkg::TimeWidth-egs_pkg::BlipWidth){1'b0}}, item.blip_ms};
          n.output_pin_level = 1'b0;
        end
      end
      egs_pkg::FN_CANCEL_BLIP: begin
        if ((st.blip_wake_time != '0) && st.output_active) begin
          n.output_pin_level = 1'b1;
        end
        n.blip_wake_time = '0;
      end
      egs_pkg::FN_DISABLE_ALL, egs_pkg::FN_INIT: begin
        n.bus_pin_level = 1'b0;
        n.bus_requested = 1'b0;
        n.bus_switching = 1'b0;
        n.blip_wake_time = '0;
        n.output_pin_level = 1'b0;
        n.output_requested = 1'b0;
        n.output_switching = 1'b0;
        n.output_active = 1'b0;
        if (egs_pkg::func_t'(item.func) == egs_pkg::FN_INIT) begin
          n.initialized = 1'b1;
        end
      end
      default: begin
        n = st;
      end
    endcase
  end

  always_comb begin
    os = n.output_requested &&
         egs_pkg::elapsed(n.now_ms, n.output_switch_start, cfg.switch_delay_ms);
    bs = n.bus_requested &&
         egs_pkg::elapsed(n.now_ms, n.bus_switch_start, cfg.switch_delay_ms);
    st_next = n;
    result.output_pin = n.output_pin_level;
    result.bus_pin = n.bus_pin_level;
    result.output_really_on = n.output_active;
    result.output_requested_settled = os;
    result.bus_requested_settled = bs;
    result.all_off = !os && !bs;
    result.blipping = (n.blip_wake_time != '0);
  end

endmodule

`default_nettype wire

### design/exclusive_gate_switch_with_blip_core.sv
// Top level of the exclusive gate switch with blip: input register, state,
// configuration registers and result register. Uses egs_pkg and egs_step.
`default_nettype none

// Break-before-make controller for an output gate and a bus input gate.
// Each item is a command or a millisecond tick; every item yields one
// result with the two pin levels and the status flags. The block takes one
// item per clock while the output is not stalled: the item is registered,
// then the whole state update (a 32-bit elapsed-time subtract and compare
// per gate and the blip deadline compare) is done combinationally into the
// state and result registers. A stalled result holds the pipe; up to two
// items wait inside. Write configuration only while idle.

module exclusive_gate_switch_with_blip_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire egs_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output egs_pkg::out_item_t   out_item,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_index,
  input  wire [egs_pkg::BlipWidth-1:0] cfg_data
);

  logic s1_valid;
  egs_pkg::in_item_t s1_item;
  logic s1_move;
  logic step_en;
  egs_pkg::state_t st;
  egs_pkg::state_t st_next;
  egs_pkg::cfg_t cfg;
  egs_pkg::out_item_t result;

  assign s1_move = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_move;
  assign step_en = s1_valid && s1_move;

  egs_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
    if (step_en) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.switch_delay_ms <= egs_pkg::SwitchDelayReset;
      cfg.blip_max_ms <= egs_pkg::BlipMaxReset;
    end else if (cfg_wr_en) begin
      case (egs_pkg::reg_index_t'(cfg_index))
        egs_pkg::REG_SWITCH_DELAY: begin
          cfg.switch_delay_ms <= cfg_data[egs_pkg::DelayWidth-1:0];
        end
        egs_pkg::REG_BLIP_MAX: begin
          cfg.blip_max_ms <= cfg_data;
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(st.output_pin_level && st.bus_pin_level))
    else $error("both gate pins driven");

  a_pin_needs_active: assert property (@(posedge clk) disable iff (rst)
    st.output_pin_level |-> st.output_active)
    else $error("output pin high while output gate not active");

  a_blip_needs_active: assert property (@(posedge clk) disable iff (rst)
    (st.blip_wake_time != '0) |-> st.output_active)
    else $error("blip pending while output gate not active");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(st))
    else $error("state changed without an item");
`endif

endmodule

`default_nettype wire
